// ----- rtl/signed_decimal_field_formatter_macros.svh -----
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_MACROS_SVH

// same-cycle implication, clocked on clk, held off during rst
`define SDFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sdff_pkg.sv -----
package sdff_pkg;

  localparam int MAX_FIELD  = 64;
  localparam int MAX_DIGITS = 10;
  localparam int LEN_W      = 7;
  localparam int ND_W       = 4;
  localparam int DIGS_W     = 4 * MAX_DIGITS;
  localparam int IN_W       = 56;
  localparam int OUT_W      = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // ceil(2^35 / 10), exact quotient for any 32-bit value
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [LEN_W-1:0]  lead;
    logic              has_sign;
    logic [7:0]        sign_ch;
    logic [LEN_W-1:0]  zeros;
    logic [ND_W-1:0]   nd;
    logic [DIGS_W-1:0] digs;
    logic [LEN_W-1:0]  trail;
    logic [LEN_W-1:0]  total;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/signed_decimal_field_formatter.sv -----
// Formats one signed 32-bit value per input transfer as printf-style decimal
// text and sends it out one ASCII character per output transfer, with tlast on
// the final character and the run length beside every character; an empty
// run sends nothing. The front end takes an item, then derives one decimal
// digit per cycle through a reciprocal multiply, and takes no new item until
// its job is pushed or dropped as empty. A two-entry job queue lets it work on
// the next value while the back end emits the previous one at one character
// per cycle when m_tready allows, loading each job from the queue between runs,
// so throughput is output-bound for most fields.
`include "signed_decimal_field_formatter_macros.svh"

module signed_decimal_field_formatter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // value[31:0], field_width[38:32], has_precision[39], precision_digits[45:40],
  // zero_pad[46], left_align[47], space_flag[48], plus_flag[49], zero fill
  input  logic [sdff_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // character[7:0], total_length[14:8], zero fill
  output logic [sdff_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);

  sdff_pkg::job_t    push_job;
  sdff_pkg::job_t    pop_job;
  sdff_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;
  logic              len_ok;

  sdff_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_stat.full),
    .push     (push),
    .job      (push_job)
  );

  sdff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  sdff_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_stat.empty),
    .job      (pop_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  assign len_ok = (m_tdata[14:8] != 7'd0) && (m_tdata[14:8] <= 7'(sdff_pkg::MAX_FIELD));

  `SDFF_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "job pushed into full queue")
  `SDFF_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "job popped from empty queue")
  `SDFF_ASSERT_NOW(a_len_range, m_tvalid, len_ok, "run length out of range")
  `SDFF_ASSERT_NEXT(a_front_wait, push && !s_tready, s_tready, "front stuck after push")

endmodule

// ----- rtl/sdff_front.sv -----
module sdff_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sdff_pkg::IN_W-1:0]  s_tdata,
  input  logic                       q_full,
  output logic                       push,
  output sdff_pkg::job_t             job
);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_t;

  state_t                           state;
  logic [31:0]                      m;
  logic [sdff_pkg::ND_W-1:0]        nd;
  logic [sdff_pkg::DIGS_W-1:0]      digs;
  logic                             neg;
  logic [sdff_pkg::LEN_W-1:0]       fw;
  logic                             hp;
  logic [5:0]                       prec;
  logic                             zpad;
  logic                             left;
  logic                             spc;
  logic                             plus;

  logic [31:0] raw;
  logic [31:0] mag;
  logic [6:0]  fw_in;
  logic [63:0] prod;
  logic [31:0] q;
  logic [31:0] q_x10;
  logic [31:0] rem;

  logic       sign_on;
  logic [7:0] body;
  logic [7:0] zeros;
  logic [7:0] pad;
  logic [7:0] total;

  assign raw   = s_tdata[31:0];
  assign mag   = raw[31] ? (32'd0 - raw) : raw;
  assign fw_in = (s_tdata[38:32] > 7'(sdff_pkg::MAX_FIELD)) ?
                 7'(sdff_pkg::MAX_FIELD) : s_tdata[38:32];

  // one decimal digit per cycle by reciprocal multiply
  assign prod  = m * sdff_pkg::RECIP10;
  assign q     = {3'b000, prod[63:35]};
  assign q_x10 = (q << 3) + (q << 1);
  assign rem   = m - q_x10;

  always_comb begin
    sign_on = neg | spc | plus;
    body    = {4'b0000, nd} + {7'b0000000, sign_on};
    zeros   = 8'd0;
    if (zpad && !left && ({1'b0, fw} > body)) begin
      zeros = {1'b0, fw} - body;
    end
    if (hp && ({2'b00, prec} > {4'b0000, nd})) begin
      zeros = {2'b00, prec} - {4'b0000, nd};
    end
    pad = 8'd0;
    if ({1'b0, fw} > (body + zeros)) begin
      pad = {1'b0, fw} - body - zeros;
    end
    total = body + zeros + pad;
  end

  always_comb begin
    job.lead     = left ? '0 : pad[6:0];
    job.trail    = left ? pad[6:0] : '0;
    job.has_sign = sign_on;
    job.sign_ch  = neg ? sdff_pkg::CH_MINUS :
                   (spc ? sdff_pkg::CH_SPACE : sdff_pkg::CH_PLUS);
    job.zeros    = zeros[6:0];
    job.nd       = nd;
    job.digs     = digs;
    job.total    = total[6:0];
  end

  assign s_tready = (state == ST_IDLE);
  assign push     = (state == ST_PUSH) && !q_full && (total != 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            m    <= mag;
            nd   <= '0;
            digs <= '0;
            neg  <= raw[31];
            fw   <= fw_in;
            hp   <= s_tdata[39];
            prec <= s_tdata[45:40];
            zpad <= s_tdata[46];
            left <= s_tdata[47];
            spc  <= s_tdata[48];
            plus <= s_tdata[49];
            // zero with precision zero prints no digit
            if (mag == 32'd0 && s_tdata[39] && s_tdata[45:40] == 6'd0) begin
              state <= ST_PUSH;
            end else begin
              state <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          m    <= q;
          nd   <= nd + 1'b1;
          digs <= {digs[sdff_pkg::DIGS_W-5:0], rem[3:0]};
          if (q == 32'd0) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full || total == 8'd0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/sdff_queue.sv -----
module sdff_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sdff_pkg::job_t    push_job,
  input  logic              pop,
  output sdff_pkg::job_t    pop_job,
  output sdff_pkg::q_stat_t stat
);

  sdff_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign pop_job    = entries[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/sdff_back.sv -----
module sdff_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  sdff_pkg::job_t             job,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sdff_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);

  logic                        busy;
  logic [sdff_pkg::LEN_W-1:0]  lead;
  logic                        has_sign;
  logic [7:0]                  sign_ch;
  logic [sdff_pkg::LEN_W-1:0]  zeros;
  logic [sdff_pkg::ND_W-1:0]   nd;
  logic [sdff_pkg::DIGS_W-1:0] digs;
  logic [sdff_pkg::LEN_W-1:0]  trail;
  logic [sdff_pkg::LEN_W-1:0]  left_cnt;
  logic [sdff_pkg::LEN_W-1:0]  total;

  logic [7:0]                  out_char;
  logic                        out_last;
  logic [sdff_pkg::LEN_W-1:0]  out_total;

  logic                        adv;
  logic                        emit;
  logic [7:0]                  ch;

  assign adv  = !m_tvalid || m_tready;
  assign emit = busy && adv;
  assign pop  = !busy && !q_empty;

  // digits sit most significant first in the low nibble
  always_comb begin
    if (lead != '0) begin
      ch = sdff_pkg::CH_SPACE;
    end else if (has_sign) begin
      ch = sign_ch;
    end else if (zeros != '0) begin
      ch = sdff_pkg::CH_ZERO;
    end else if (nd != '0) begin
      ch = sdff_pkg::CH_ZERO + {4'h0, digs[3:0]};
    end else begin
      ch = sdff_pkg::CH_SPACE;
    end
  end

  assign m_tdata = {1'b0, out_total, out_char};
  assign m_tlast = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= busy;
      end
      if (pop) begin
        busy     <= 1'b1;
        lead     <= job.lead;
        has_sign <= job.has_sign;
        sign_ch  <= job.sign_ch;
        zeros    <= job.zeros;
        nd       <= job.nd;
        digs     <= job.digs;
        trail    <= job.trail;
        left_cnt <= job.total;
        total    <= job.total;
      end else if (emit) begin
        out_char  <= ch;
        out_last  <= (left_cnt == 7'd1);
        out_total <= total;
        left_cnt  <= left_cnt - 1'b1;
        if (left_cnt == 7'd1) begin
          busy <= 1'b0;
        end
        if (lead != '0) begin
          lead <= lead - 1'b1;
        end else if (has_sign) begin
          has_sign <= 1'b0;
        end else if (zeros != '0) begin
          zeros <= zeros - 1'b1;
        end else if (nd != '0) begin
          nd   <= nd - 1'b1;
          digs <= digs >> 4;
        end else begin
          trail <= trail - 1'b1;
        end
      end
    end
  end

endmodule
